// ===== design/yfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yfb_pkg
// Shared types, constants and color helpers for the YUYV to RGB565
// framebuffer writer.
// ----------------------------------------------------------------------------
package yfb_pkg;

  // field and register widths
  localparam int unsigned SampleW   = 8;
  localparam int unsigned CfgW      = 13;
  localparam int unsigned CountW    = 12;
  localparam int unsigned PixW      = 16;
  localparam int unsigned PixAddrW  = 24;
  localparam int unsigned InDataW   = 4 * SampleW;
  localparam int unsigned OutDataW  = PixAddrW + 2 * PixW;
  localparam int unsigned ChanW     = 20;
  localparam int unsigned DefAddrBits = 24;

  // register reset values
  localparam logic [CfgW-1:0] ImageWidthRst  = 13'd800;
  localparam logic [CfgW-1:0] ImageHeightRst = 13'd600;
  localparam logic [CfgW-1:0] ScreenWidthRst = 13'd800;
  localparam logic [CfgW-1:0] MaxRows        = 13'd4096;

  // conversion coefficients
  localparam logic signed [ChanW-1:0] CoefY    = 20'sd298;
  localparam logic signed [ChanW-1:0] CoefRV   = 20'sd409;
  localparam logic signed [ChanW-1:0] CoefGU   = 20'sd100;
  localparam logic signed [ChanW-1:0] CoefGV   = 20'sd208;
  localparam logic signed [ChanW-1:0] CoefBU   = 20'sd516;
  localparam logic signed [ChanW-1:0] RoundAdd = 20'sd128;
  localparam logic signed [SampleW+1:0] ChromaOfs = 10'sd128;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_SCREEN_WIDTH = 2'd2
  } cfg_reg_t;

  // clamp a scaled channel sum to 0..255 after dropping 8 fraction bits
  function automatic logic [SampleW-1:0] sat_channel(input logic signed [ChanW-1:0] sum);
    logic [SampleW-1:0] res;
    if (sum[ChanW-1]) begin
      res = '0;
    end else if (|sum[ChanW-2:2*SampleW]) begin
      res = '1;
    end else begin
      res = sum[2*SampleW-1:SampleW];
    end
    return res;
  endfunction

  // pack three 8-bit channels as RGB565
  function automatic logic [PixW-1:0] pack_rgb565(input logic [SampleW-1:0] r,
                                                  input logic [SampleW-1:0] g,
                                                  input logic [SampleW-1:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

// ===== design/yuyv_to_rgb565_framebuffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuyv_to_rgb565_framebuffer
// Converts YUYV macropixels to RGB565 pixel pairs with framebuffer addresses.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one YUYV macropixel per request (Y0, U, Y1, V from the low byte).
//   out_* : framebuffer word address of the first pixel plus two RGB565
//           words; out_tlast flags the last pair of the frame.
//   cfg_* : image width, image height and screen width, written while idle.
// Throughput is one macropixel per clock while out_tready stays high. A
// visible pair passes the product register (chroma and luma products),
// then the output register (clamped result) that drives out_tvalid.
// Pairs beyond the screen width advance the row and column counters but
// produce no output request. Row pitch is the screen width rounded up to
// even; counters wrap to the frame origin after the last row.
// A stalled out_tready holds the output register and back-pressures the
// product stage, and in_tready drops only when both stages are full.
// Reset clears counters and valid flags and restores the 800x600 defaults.
// ----------------------------------------------------------------------------
module yuyv_to_rgb565_framebuffer #(
  parameter int unsigned ADDR_BITS = yfb_pkg::DefAddrBits
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [yfb_pkg::CfgW-1:0]       cfg_wdata,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // luma_first, chroma_blue, luma_second, chroma_red (from the low bit up)
  input  logic [yfb_pkg::InDataW-1:0]    in_tdata,
  // output stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // pixel_address, first_pixel, second_pixel (from the low bit up)
  output logic [yfb_pkg::OutDataW-1:0]   out_tdata,
  output logic                           out_tlast
);

  localparam int unsigned SW = yfb_pkg::SampleW;
  localparam int unsigned CW = yfb_pkg::ChanW;
  localparam int unsigned NW = yfb_pkg::CountW;

  // configuration registers
  logic [yfb_pkg::CfgW-1:0] img_width_r, img_height_r, scr_width_r;

  // position counters
  logic [NW-1:0]        col_r, col_nxt;
  logic [NW-1:0]        row_r, row_nxt;
  logic [ADDR_BITS-1:0] row_base_r, row_base_nxt;

  // product stage
  logic                     s1_valid_r;
  logic [yfb_pkg::PixAddrW-1:0] s1_addr_r, s1_addr_nxt;
  logic                     s1_last_r, s1_last_nxt;
  logic signed [CW-1:0]     s1_yt0_r, s1_yt1_r, s1_rv_r, s1_g_r, s1_bu_r;
  logic signed [CW-1:0]     s1_yt0_nxt, s1_yt1_nxt, s1_rv_nxt, s1_g_nxt, s1_bu_nxt;

  // output stage
  logic                            out_valid_r;
  logic [yfb_pkg::OutDataW-1:0]    out_data_r, out_data_nxt;
  logic                            out_last_r;

  // handshake and position decode
  logic                 in_acc, s1_adv, out_free, visible;
  logic [NW:0]          next_col, next_row, rows;
  logic                 row_end, frame_end;
  logic [NW-1:0]        pairs;
  logic [yfb_pkg::CfgW:0] pitch;
  logic [ADDR_BITS-1:0] addr;
  logic [ADDR_BITS+yfb_pkg::PixAddrW-1:0] addr_ext;

  // chroma and luma terms
  logic signed [SW+1:0] ub_s, vr_s;
  logic [SW-1:0]        y0, y1;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= yfb_pkg::ImageWidthRst;
      img_height_r <= yfb_pkg::ImageHeightRst;
      scr_width_r  <= yfb_pkg::ScreenWidthRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        yfb_pkg::CFG_IMAGE_WIDTH:  img_width_r  <= cfg_wdata;
        yfb_pkg::CFG_IMAGE_HEIGHT: img_height_r <= cfg_wdata;
        yfb_pkg::CFG_SCREEN_WIDTH: scr_width_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline flow
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  // position decode for the incoming pair
  always_comb begin
    pairs     = img_width_r[yfb_pkg::CfgW-1:1];
    rows      = (img_height_r > yfb_pkg::MaxRows) ? yfb_pkg::MaxRows : img_height_r;
    pitch     = ({1'b0, scr_width_r} + 14'd1) & ~14'd1;
    next_col  = {1'b0, col_r} + 13'd1;
    next_row  = {1'b0, row_r} + 13'd1;
    row_end   = next_col >= {1'b0, pairs};
    frame_end = row_end && (next_row >= rows);
    visible   = {col_r, 1'b0} < scr_width_r;
    addr      = row_base_r + ADDR_BITS'({col_r, 1'b0});
    addr_ext  = {{yfb_pkg::PixAddrW{1'b0}}, addr};

    col_nxt      = next_col[NW-1:0];
    row_nxt      = row_r;
    row_base_nxt = row_base_r;
    if (row_end) begin
      col_nxt = '0;
      if (frame_end) begin
        row_nxt      = '0;
        row_base_nxt = '0;
      end else begin
        row_nxt      = next_row[NW-1:0];
        row_base_nxt = row_base_r + ADDR_BITS'(pitch);
      end
    end
  end

  // counters advance on every accepted pair, visible or not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      row_base_r <= '0;
    end else if (in_acc) begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      row_base_r <= row_base_nxt;
    end
  end

  // product terms of the color matrix
  always_comb begin
    y0   = in_tdata[SW-1:0];
    y1   = in_tdata[3*SW-1:2*SW];
    ub_s = $signed({2'b00, in_tdata[2*SW-1:SW]}) - yfb_pkg::ChromaOfs;
    vr_s = $signed({2'b00, in_tdata[4*SW-1:3*SW]}) - yfb_pkg::ChromaOfs;

    s1_yt0_nxt  = yfb_pkg::CoefY * $signed(CW'(y0)) + yfb_pkg::RoundAdd;
    s1_yt1_nxt  = yfb_pkg::CoefY * $signed(CW'(y1)) + yfb_pkg::RoundAdd;
    s1_rv_nxt   = yfb_pkg::CoefRV * CW'(vr_s);
    s1_g_nxt    = yfb_pkg::CoefGU * CW'(ub_s) + yfb_pkg::CoefGV * CW'(vr_s);
    s1_bu_nxt   = yfb_pkg::CoefBU * CW'(ub_s);
    s1_addr_nxt = addr_ext[yfb_pkg::PixAddrW-1:0];
    s1_last_nxt = frame_end;
  end

  // product stage registers; only visible pairs enter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= visible;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_yt0_r  <= s1_yt0_nxt;
      s1_yt1_r  <= s1_yt1_nxt;
      s1_rv_r   <= s1_rv_nxt;
      s1_g_r    <= s1_g_nxt;
      s1_bu_r   <= s1_bu_nxt;
      s1_addr_r <= s1_addr_nxt;
      s1_last_r <= s1_last_nxt;
    end
  end

  // channel sums, clamp and pack
  always_comb begin
    out_data_nxt = {
      yfb_pkg::pack_rgb565(yfb_pkg::sat_channel(s1_yt1_r + s1_rv_r),
                           yfb_pkg::sat_channel(s1_yt1_r - s1_g_r),
                           yfb_pkg::sat_channel(s1_yt1_r + s1_bu_r)),
      yfb_pkg::pack_rgb565(yfb_pkg::sat_channel(s1_yt0_r + s1_rv_r),
                           yfb_pkg::sat_channel(s1_yt0_r - s1_g_r),
                           yfb_pkg::sat_channel(s1_yt0_r + s1_bu_r)),
      s1_addr_r
    };
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== design/yfb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yfb_checker
// Port-level checks for the YUYV to RGB565 framebuffer writer.
// ----------------------------------------------------------------------------
module yfb_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [yfb_pkg::OutDataW-1:0] out_tdata,
  input logic                         out_tlast
);

  // a stalled output request keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output request changed while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // a ready receiver never back-pressures the input
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output is taken");

  // a new output request comes from an accepted pair that passed the product stage
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("output request without matching input");

endmodule

bind yuyv_to_rgb565_framebuffer yfb_checker u_yfb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== test/yfb_pixel_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yfb_pixel_checker
// Watches the configuration port and both streams of the YUYV to RGB565
// framebuffer writer. Every accepted macropixel request is run through an
// independent raster and color predictor. Visible pairs are queued, and each
// output request is compared field by field with the oldest queued pair.
// ----------------------------------------------------------------------------
module yfb_pixel_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [yfb_pkg::CfgW-1:0]      cfg_wdata,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [yfb_pkg::InDataW-1:0]   in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [yfb_pkg::OutDataW-1:0]  out_tdata,
  input  logic                          out_tlast,
  output int unsigned                   pairs_due,
  output int unsigned                   mismatch_count
);

  localparam int unsigned CfgW     = yfb_pkg::CfgW;
  localparam int unsigned CountW   = yfb_pkg::CountW;
  localparam int unsigned PixW     = yfb_pkg::PixW;
  localparam int unsigned PixAddrW = yfb_pkg::PixAddrW;
  localparam int unsigned InDataW  = yfb_pkg::InDataW;
  localparam int unsigned OutDataW = yfb_pkg::OutDataW;

  typedef struct packed {
    logic [PixAddrW-1:0] address;
    logic [PixW-1:0]     first_px;
    logic [PixW-1:0]     second_px;
    logic                frame_end;
  } pixel_pair_t;

  // shadow copy of the registers
  logic [CfgW-1:0]     img_width;
  logic [CfgW-1:0]     img_height;
  logic [CfgW-1:0]     scr_width;

  // raster position
  logic [CountW-1:0]   col_pair;
  logic [CountW-1:0]   row_idx;
  logic [PixAddrW-1:0] row_base;

  pixel_pair_t pixel_pairs_due[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 40) begin
      $display("%0t: mismatch %s: got %0h, want %0h", $realtime, what, got, want);
    end
    mismatch_count = mismatch_count + 1;
  endtask

  // clamp after dropping the 8 fraction bits
  function automatic logic [7:0] clamp_channel(input int sum);
    if (sum < 0) return 8'd0;
    if (sum / 256 > 255) return 8'd255;
    return 8'(sum / 256);
  endfunction

  function automatic logic [PixW-1:0] rgb565_of(input logic [7:0] luma,
                                                input logic [7:0] cb,
                                                input logic [7:0] cr);
    int ub;
    int vr;
    int yt;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    ub = int'(cb);
    ub = ub - 128;
    vr = int'(cr);
    vr = vr - 128;
    yt = int'(luma);
    yt = 298 * yt + 128;
    r = clamp_channel(yt + 409 * vr);
    g = clamp_channel(yt - 100 * ub - 208 * vr);
    b = clamp_channel(yt + 516 * ub);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  // advance the raster for one macropixel, queue the pair if it is visible
  task automatic place_macropixel(input logic [InDataW-1:0] mp);
    logic [CfgW-1:0]     pairs;
    logic [CfgW-1:0]     rows;
    logic [CfgW-1:0]     next_col;
    logic [CfgW-1:0]     next_row;
    logic [CfgW:0]       pitch;
    logic                visible;
    logic                frame_end;
    logic [PixAddrW-1:0] addr;
    pixel_pair_t         pair;
    pairs     = {1'b0, img_width[CfgW-1:1]};
    rows      = (img_height > yfb_pkg::MaxRows) ? yfb_pkg::MaxRows : img_height;
    pitch     = {1'b0, scr_width} + 14'd1;
    pitch[0]  = 1'b0;
    next_col  = {1'b0, col_pair} + 13'd1;
    frame_end = 1'b0;
    visible   = {col_pair, 1'b0} < scr_width;
    addr      = row_base + PixAddrW'({col_pair, 1'b0});

    if (next_col >= pairs) begin
      next_row  = {1'b0, row_idx} + 13'd1;
      frame_end = next_row >= rows;
      col_pair  = '0;
      if (frame_end) begin
        row_idx  = '0;
        row_base = '0;
      end else begin
        row_idx  = next_row[CountW-1:0];
        row_base = row_base + PixAddrW'(pitch);
      end
    end else begin
      col_pair = next_col[CountW-1:0];
    end

    if (visible) begin
      pair.address   = addr;
      pair.first_px  = rgb565_of(mp[7:0], mp[15:8], mp[31:24]);
      pair.second_px = rgb565_of(mp[23:16], mp[15:8], mp[31:24]);
      pair.frame_end = frame_end;
      pixel_pairs_due.push_back(pair);
    end
  endtask

  always @(posedge clk) begin
    pixel_pair_t want;
    if (!rst_n) begin
      img_width      = yfb_pkg::ImageWidthRst;
      img_height     = yfb_pkg::ImageHeightRst;
      scr_width      = yfb_pkg::ScreenWidthRst;
      col_pair       = '0;
      row_idx        = '0;
      row_base       = '0;
      mismatch_count = 0;
      pixel_pairs_due.delete();
    end else begin
      // compare the output request first so a pair queued this edge is not used
      if (out_tvalid && out_tready) begin
        if (pixel_pairs_due.size() == 0) begin
          report_mismatch("result with none due", 32'(out_tdata[PixAddrW-1:0]), '0);
        end else begin
          want = pixel_pairs_due.pop_front();
          if (out_tdata[PixAddrW-1:0] !== want.address)
            report_mismatch("pixel_address", 32'(out_tdata[PixAddrW-1:0]),
                            32'(want.address));
          if (out_tdata[PixAddrW+PixW-1:PixAddrW] !== want.first_px)
            report_mismatch("first_pixel", 32'(out_tdata[PixAddrW+PixW-1:PixAddrW]),
                            32'(want.first_px));
          if (out_tdata[OutDataW-1:PixAddrW+PixW] !== want.second_px)
            report_mismatch("second_pixel", 32'(out_tdata[OutDataW-1:PixAddrW+PixW]),
                            32'(want.second_px));
          if (out_tlast !== want.frame_end)
            report_mismatch("frame_last", 32'(out_tlast), 32'(want.frame_end));
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          yfb_pkg::CFG_IMAGE_WIDTH:  img_width  = cfg_wdata;
          yfb_pkg::CFG_IMAGE_HEIGHT: img_height = cfg_wdata;
          yfb_pkg::CFG_SCREEN_WIDTH: scr_width  = cfg_wdata;
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        place_macropixel(in_tdata);
      end
    end
    pairs_due <= pixel_pairs_due.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the YUYV to RGB565 framebuffer writer. Runs a few
// hand-picked color extremes, short frames that hit narrow images, one-row
// frames, unreported frame ends and a zero screen width, random small frames,
// and one long frame of one-pair rows at the widest pitch.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CfgW     = yfb_pkg::CfgW;
  localparam int unsigned InDataW  = yfb_pkg::InDataW;
  localparam int unsigned OutDataW = yfb_pkg::OutDataW;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RxHoldCycles = 300;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [CfgW-1:0]     cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tlast;

  int unsigned pairs_due;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  // stimulus knobs shared with the receiver
  bit no_gaps;
  bit rx_hold_go;
  bit rx_hold_done;

  yuyv_to_rgb565_framebuffer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  yfb_pixel_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .pairs_due      (pairs_due),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off, none while no_gaps is set
  initial begin
    out_tready = 1'b0;
    rx_hold_done = 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_go && !rx_hold_done) begin
        out_tready <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk);
        rx_hold_done = 1'b1;
      end else begin
        out_tready <= no_gaps || ($urandom_range(99) >= 16);
        @(posedge clk);
      end
    end
  end

  // offer one macropixel request and wait until it is taken
  task automatic send_samples(input logic [7:0] y0, input logic [7:0] u,
                              input logic [7:0] y1, input logic [7:0] v);
    while (!no_gaps && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {v, y1, u, y0};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // wait for every queued pair, then let the pipeline empty
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pairs_due != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // write all three registers, then send random macropixels
  task automatic run_frame_phase(input logic [CfgW-1:0] width,
                                 input logic [CfgW-1:0] height,
                                 input logic [CfgW-1:0] screen,
                                 input int unsigned n_items);
    cfg_we    <= 1'b1;
    cfg_index <= yfb_pkg::CFG_IMAGE_WIDTH;
    cfg_wdata <= width;
    @(posedge clk);
    cfg_index <= yfb_pkg::CFG_IMAGE_HEIGHT;
    cfg_wdata <= height;
    @(posedge clk);
    cfg_index <= yfb_pkg::CFG_SCREEN_WIDTH;
    cfg_wdata <= screen;
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (n_items) begin
      send_samples(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
    end
    drain_results();
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = yfb_pkg::CFG_IMAGE_WIDTH;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    no_gaps    = 1'b0;
    rx_hold_go = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // color extremes at the reset geometry
    send_samples(8'd0,   8'd128, 8'd255, 8'd128);
    send_samples(8'd255, 8'd0,   8'd0,   8'd0);
    send_samples(8'd255, 8'd255, 8'd255, 8'd255);
    send_samples(8'd0,   8'd0,   8'd0,   8'd0);
    send_samples(8'd0,   8'd255, 8'd0,   8'd255);
    send_samples(8'd128, 8'd0,   8'd128, 8'd255);
    send_samples(8'd128, 8'd255, 8'd128, 8'd0);
    send_samples(8'd16,  8'd128, 8'd235, 8'd128);
    send_samples(8'd255, 8'd255, 8'd0,   8'd0);
    send_samples(8'd0,   8'd0,   8'd255, 8'd255);
    send_samples(8'd81,  8'd90,  8'd145, 8'd240);
    send_samples(8'd170, 8'd85,  8'd85,  8'd170);
    drain_results();

    // narrow image: one macropixel per row
    run_frame_phase(13'd1, 13'd3, 13'd4, 10);
    // zero height: one row per frame, frame end visible
    run_frame_phase(13'd6, 13'd0, 13'd5, 9);
    // frame end falls on an invisible pair
    run_frame_phase(13'd8, 13'd1, 13'd5, 9);
    // zero screen width: nothing is written
    run_frame_phase(13'd4, 13'd2, 13'd0, 8);

    // random small frames, one without gaps, one with a long receiver stall
    for (int p = 0; p < 10; p++) begin
      no_gaps = (p == 3);
      rx_hold_go = (p == 6);
      run_frame_phase(CfgW'($urandom_range(0, 20)), CfgW'($urandom_range(0, 5)),
                      CfgW'($urandom_range(0, 24)), 60);
    end
    no_gaps = 1'b0;

    // widest settings within a single row
    run_frame_phase(13'h1FFF, 13'h1FFF, 13'h1FFF, 40);
    // one pair per row at the widest pitch
    run_frame_phase(13'd0, 13'h1FFF, 13'h1FFF, 400);
    run_frame_phase(13'd2, 13'd1, 13'd1, 20);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
